// ===== sv/rect_gap_distance_core_macros.svh =====
// assertion macros for the rectangle gap distance core
// expects signals named clock and reset in the scope of use
`ifndef RECT_GAP_DISTANCE_CORE_MACROS_SVH
`define RECT_GAP_DISTANCE_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define RGD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rgd check failed");

// next-cycle implication, off during reset
`define RGD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgd check failed");

// same-cycle implication that also runs while reset is high
`define RGD_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("rgd check failed");

`endif

// ===== sv/rgd_pkg.sv =====
// shared constants and types for the rectangle gap distance core
// no dependencies
`default_nettype none

package rgd_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int SEP_BITS           = 18;

   // control that travels alongside each request through the pipe
   typedef struct packed {
      logic valid;
      logic overlap;
      logic corner;
   } rgd_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/rgd_req_if.sv =====
// request channel: two rectangles given as left, top, width, height
// depends on rgd_pkg
`default_nettype none

interface rgd_req_if #(
   parameter int COORD_BITS = rgd_pkg::COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_left;
   logic signed [COORD_BITS-1:0] a_top;
   logic        [COORD_BITS-2:0] a_width;
   logic        [COORD_BITS-2:0] a_height;
   logic signed [COORD_BITS-1:0] b_left;
   logic signed [COORD_BITS-1:0] b_top;
   logic        [COORD_BITS-2:0] b_width;
   logic        [COORD_BITS-2:0] b_height;

   modport source (
      output valid, a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height,
      input  ready
   );
   modport sink (
      input  valid, a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/rgd_rsp_if.sv =====
// response channel: overlap flag and separation
// depends on rgd_pkg
`default_nettype none

interface rgd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 overlapping;
   logic signed [rgd_pkg::SEP_BITS-1:0]  separation;

   modport source (output valid, overlapping, separation, input ready);
   modport sink   (input valid, overlapping, separation, output ready);
endinterface

`default_nettype wire

// ===== sv/rgd_prep.sv =====
// front pipeline: edges, spans, axis gaps, squares and their sum
// depends on rgd_pkg
`default_nettype none

module rgd_prep #(
   parameter int COORD_BITS = rgd_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           adv,
   input  wire logic                           in_valid,
   input  wire logic signed [COORD_BITS-1:0]   a_left,
   input  wire logic signed [COORD_BITS-1:0]   a_top,
   input  wire logic        [COORD_BITS-2:0]   a_width,
   input  wire logic        [COORD_BITS-2:0]   a_height,
   input  wire logic signed [COORD_BITS-1:0]   b_left,
   input  wire logic signed [COORD_BITS-1:0]   b_top,
   input  wire logic        [COORD_BITS-2:0]   b_width,
   input  wire logic        [COORD_BITS-2:0]   b_height,
   output rgd_pkg::rgd_ctrl_type               ctrl_out,
   output logic             [COORD_BITS-1:0]   gap_out,
   output logic             [2*COORD_BITS+1:0] rad_out
);

   localparam int EB = COORD_BITS + 1;  // edge width
   localparam int SQ = 2 * COORD_BITS;

   // stage 1: max of left/top edges, right/bottom edges
   logic              s1_valid_ff, s1_valid_in;
   logic signed [EB-1:0] maxl_ff, maxl_in, maxt_ff, maxt_in;
   logic signed [EB-1:0] ar_ff, ar_in, br_ff, br_in, ab_ff, ab_in, bb_ff, bb_in;

   // stage 2: axis gaps and overlap
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_ovl_ff, s2_ovl_in;
   logic [COORD_BITS-1:0] gx_ff, gx_in, gy_ff, gy_in;

   // stage 3: squares
   rgd_pkg::rgd_ctrl_type s3_ctrl_ff, s3_ctrl_in;
   logic [COORD_BITS-1:0] s3_gap_ff, s3_gap_in;
   logic [SQ-1:0]         sqx_ff, sqx_in, sqy_ff, sqy_in;

   // stage 4: sum of squares
   rgd_pkg::rgd_ctrl_type s4_ctrl_ff, s4_ctrl_in;
   logic [COORD_BITS-1:0] s4_gap_ff, s4_gap_in;
   logic [SQ+1:0]         sum_ff, sum_in;

   logic signed [EB-1:0] al_x, at_x, bl_x, bt_x;
   logic signed [EB-1:0] minr, minb;
   logic signed [EB:0]   dx, dy;

   always_comb begin
      al_x = EB'(a_left);
      at_x = EB'(a_top);
      bl_x = EB'(b_left);
      bt_x = EB'(b_top);
      s1_valid_in = in_valid;
      maxl_in = (al_x > bl_x) ? al_x : bl_x;
      maxt_in = (at_x > bt_x) ? at_x : bt_x;
      ar_in = al_x + $signed({2'b00, a_width});
      br_in = bl_x + $signed({2'b00, b_width});
      ab_in = at_x + $signed({2'b00, a_height});
      bb_in = bt_x + $signed({2'b00, b_height});
   end

   always_comb begin
      minr = (ar_ff < br_ff) ? ar_ff : br_ff;
      minb = (ab_ff < bb_ff) ? ab_ff : bb_ff;
      // gap is max edge minus min far edge, negative means the spans intersect
      dx = (EB+1)'(maxl_ff) - (EB+1)'(minr);
      dy = (EB+1)'(maxt_ff) - (EB+1)'(minb);
      s2_valid_in = s1_valid_ff;
      s2_ovl_in   = dx[EB] && dy[EB];
      gx_in = (!dx[EB] && dx != '0) ? dx[COORD_BITS-1:0] : '0;
      gy_in = (!dy[EB] && dy != '0) ? dy[COORD_BITS-1:0] : '0;
   end

   always_comb begin
      s3_ctrl_in.valid   = s2_valid_ff;
      s3_ctrl_in.overlap = s2_ovl_ff;
      s3_ctrl_in.corner  = (gx_ff != '0) && (gy_ff != '0);
      s3_gap_in = (gx_ff != '0) ? gx_ff : gy_ff;
      sqx_in = SQ'(gx_ff) * SQ'(gx_ff);
      sqy_in = SQ'(gy_ff) * SQ'(gy_ff);
   end

   always_comb begin
      s4_ctrl_in = s3_ctrl_ff;
      s4_gap_in  = s3_gap_ff;
      sum_in     = (SQ+2)'(sqx_ff) + (SQ+2)'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ctrl_ff  <= '0;
         s4_ctrl_ff  <= '0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_ctrl_ff  <= s3_ctrl_in;
         s4_ctrl_ff  <= s4_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         maxl_ff   <= maxl_in;
         maxt_ff   <= maxt_in;
         ar_ff     <= ar_in;
         br_ff     <= br_in;
         ab_ff     <= ab_in;
         bb_ff     <= bb_in;
         s2_ovl_ff <= s2_ovl_in;
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;
         s3_gap_ff <= s3_gap_in;
         sqx_ff    <= sqx_in;
         sqy_ff    <= sqy_in;
         s4_gap_ff <= s4_gap_in;
         sum_ff    <= sum_in;
      end
   end

   assign ctrl_out = s4_ctrl_ff;
   assign gap_out  = s4_gap_ff;
   assign rad_out  = sum_ff;

endmodule

`default_nettype wire

// ===== sv/rgd_sqrt_cell.sv =====
// one cell of the square root chain: resolves one root bit per cell
// depends on rgd_pkg
`default_nettype none

module rgd_sqrt_cell #(
   parameter int ROOT_BITS = rgd_pkg::COORD_BITS_DEFAULT + 1,
   parameter int GAP_BITS  = rgd_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire rgd_pkg::rgd_ctrl_type  ctrl_in,
   input  wire logic [GAP_BITS-1:0]    gap_in,
   input  wire logic [2*ROOT_BITS-1:0] rad_in,
   input  wire logic [ROOT_BITS:0]     rem_in,
   input  wire logic [ROOT_BITS-1:0]   root_in,
   output rgd_pkg::rgd_ctrl_type       ctrl_out,
   output logic      [GAP_BITS-1:0]    gap_out,
   output logic      [2*ROOT_BITS-1:0] rad_out,
   output logic      [ROOT_BITS:0]     rem_out,
   output logic      [ROOT_BITS-1:0]   root_out
);

   rgd_pkg::rgd_ctrl_type  ctrl_ff;
   logic [GAP_BITS-1:0]    gap_ff, gap_nx_in;
   logic [2*ROOT_BITS-1:0] rad_ff, rad_nx_in;
   logic [ROOT_BITS:0]     rem_ff, rem_nx_in;
   logic [ROOT_BITS-1:0]   root_ff, root_nx_in;

   logic [ROOT_BITS+2:0] rem_sh, trial, diff;
   logic                 take;

   always_comb begin
      // bring down the next two radicand bits, try root*4+1
      rem_sh = {rem_in, rad_in[2*ROOT_BITS-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      take   = rem_sh >= trial;
      diff   = rem_sh - trial;
      rem_nx_in  = take ? diff[ROOT_BITS:0] : rem_sh[ROOT_BITS:0];
      root_nx_in = {root_in[ROOT_BITS-2:0], take};
      rad_nx_in  = {rad_in[2*ROOT_BITS-3:0], 2'b00};
      gap_nx_in  = gap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (adv) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gap_ff  <= gap_nx_in;
         rad_ff  <= rad_nx_in;
         rem_ff  <= rem_nx_in;
         root_ff <= root_nx_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign gap_out  = gap_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

`default_nettype wire

// ===== sv/rect_gap_distance_core.sv =====
// throughput: one request per cycle while the skid entry is empty; 4 front stages, then one root bit per chain cell
// a two-entry output (register plus skid) lets requests enter while a response waits
// reset: synchronous, clears all valid flags; no response is pending afterward
// rectangle gap distance core: top level, depends on rgd_pkg, interfaces, prep and cells
`default_nettype none

module rect_gap_distance_core #(
   parameter int COORD_BITS = rgd_pkg::COORD_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   rgd_req_if.sink    req_chan,
   rgd_rsp_if.source  rsp_chan
);

   localparam int ROOT_BITS = COORD_BITS + 1;
   localparam int SEP_BITS  = rgd_pkg::SEP_BITS;
   localparam int WIDE_BITS = ROOT_BITS + 1 + SEP_BITS;

   logic adv;

   rgd_pkg::rgd_ctrl_type  ctrl_chain [ROOT_BITS+1];
   logic [COORD_BITS-1:0]  gap_chain  [ROOT_BITS+1];
   logic [2*ROOT_BITS-1:0] rad_chain  [ROOT_BITS+1];
   logic [ROOT_BITS:0]     rem_chain  [ROOT_BITS+1];
   logic [ROOT_BITS-1:0]   root_chain [ROOT_BITS+1];

   rgd_prep #(.COORD_BITS(COORD_BITS)) u_prep (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_chan.valid),
      .a_left   (req_chan.a_left),
      .a_top    (req_chan.a_top),
      .a_width  (req_chan.a_width),
      .a_height (req_chan.a_height),
      .b_left   (req_chan.b_left),
      .b_top    (req_chan.b_top),
      .b_width  (req_chan.b_width),
      .b_height (req_chan.b_height),
      .ctrl_out (ctrl_chain[0]),
      .gap_out  (gap_chain[0]),
      .rad_out  (rad_chain[0])
   );

   assign rem_chain[0]  = '0;
   assign root_chain[0] = '0;

   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
      rgd_sqrt_cell #(.ROOT_BITS(ROOT_BITS), .GAP_BITS(COORD_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .ctrl_in  (ctrl_chain[i]),
         .gap_in   (gap_chain[i]),
         .rad_in   (rad_chain[i]),
         .rem_in   (rem_chain[i]),
         .root_in  (root_chain[i]),
         .ctrl_out (ctrl_chain[i+1]),
         .gap_out  (gap_chain[i+1]),
         .rad_out  (rad_chain[i+1]),
         .rem_out  (rem_chain[i+1]),
         .root_out (root_chain[i+1])
      );
   end

   // round to nearest: bump the root when the remainder exceeds it
   rgd_pkg::rgd_ctrl_type last_ctrl;
   logic [ROOT_BITS:0]    rounded;
   logic [WIDE_BITS-1:0]  wide;
   logic                  res_ovl;
   logic [SEP_BITS-1:0]   res_sep;
   logic                  push;

   always_comb begin
      last_ctrl = ctrl_chain[ROOT_BITS];
      rounded = (ROOT_BITS+1)'(root_chain[ROOT_BITS])
              + (ROOT_BITS+1)'(rem_chain[ROOT_BITS] > (ROOT_BITS+1)'(root_chain[ROOT_BITS]));
      wide = last_ctrl.corner ? WIDE_BITS'(rounded) : WIDE_BITS'(gap_chain[ROOT_BITS]);
      res_ovl = last_ctrl.overlap;
      res_sep = last_ctrl.overlap ? '1 : wide[SEP_BITS-1:0];
      push    = adv && last_ctrl.valid;
   end

   // output register plus skid entry
   logic                out_valid_ff, out_valid_in;
   logic                out_ovl_ff, out_ovl_in;
   logic [SEP_BITS-1:0] out_sep_ff, out_sep_in;
   logic                skid_valid_ff, skid_valid_in;
   logic                skid_ovl_ff, skid_ovl_in;
   logic [SEP_BITS-1:0] skid_sep_ff, skid_sep_in;

   assign adv = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_ovl_in    = out_ovl_ff;
      out_sep_in    = out_sep_ff;
      skid_valid_in = skid_valid_ff;
      skid_ovl_in   = skid_ovl_ff;
      skid_sep_in   = skid_sep_ff;
      if (!out_valid_ff || rsp_chan.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_ovl_in    = skid_ovl_ff;
            out_sep_in    = skid_sep_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_ovl_in   = res_ovl;
            out_sep_in   = res_sep;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_ovl_in   = res_ovl;
         skid_sep_in   = res_sep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ovl_ff  <= out_ovl_in;
      out_sep_ff  <= out_sep_in;
      skid_ovl_ff <= skid_ovl_in;
      skid_sep_ff <= skid_sep_in;
   end

   assign req_chan.ready       = adv;
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.overlapping = out_ovl_ff;
   assign rsp_chan.separation  = out_sep_ff;

endmodule

`default_nettype wire

// ===== sv/rgd_checker.sv =====
// port-level checks for the rectangle gap distance core, bound to the top level
// depends on rgd_pkg and rect_gap_distance_core_macros.svh
`default_nettype none

`include "rect_gap_distance_core_macros.svh"

module rgd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_overlapping,
   input wire logic [rgd_pkg::SEP_BITS-1:0]  rsp_separation
);

   // a stalled response stays offered
   `RGD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // overlap always reports separation of minus one
   `RGD_ASSERT_IMPL(a_ovl_sep, rsp_valid && rsp_overlapping, rsp_separation == '1)

   // nothing is offered right after reset
   `RGD_ASSERT_ALWAYS(a_rst_empty, $past(reset) && !reset, !rsp_valid)

   // while the output is stalled and requests are blocked, the next cycle still offers one
   `RGD_ASSERT_NEXT(a_block_full, rsp_valid && !rsp_ready && !req_ready && !req_valid,
                    rsp_valid && !req_ready)

endmodule

bind rect_gap_distance_core rgd_checker u_rgd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_overlapping (rsp_chan.overlapping),
   .rsp_separation  (rsp_chan.separation)
);

`default_nettype wire
